// File: hw/rtl/kle_pkg.sv
// Shared constants and codes for the keystroke line editor.
`timescale 1ns / 1ps

package kle_pkg;

    // Byte width of a key and of an emitted character
    localparam int KEY_W = 8;

    // Width of the configuration register index
    localparam int CFG_IDX_W = 2;

    // Request operations
    localparam logic OP_KEY    = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BACKSPACE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT     = 2'd2;

    // Reset values of the key codes
    localparam logic [KEY_W-1:0] BACKSPACE_RESET = 8'd45;
    localparam logic [KEY_W-1:0] LEFT_RESET      = 8'd60;
    localparam logic [KEY_W-1:0] RIGHT_RESET     = 8'd62;

endpackage

// File: hw/rtl/kle_req_if.sv
// Request channel interface: one keystroke or finish request.
`timescale 1ns / 1ps

interface kle_req_if;
    import kle_pkg::*;

    logic             valid;
    logic             ready;
    logic             op;
    logic [KEY_W-1:0] key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

// File: hw/rtl/kle_res_if.sv
// Result channel interface: one character of the finished line.
`timescale 1ns / 1ps

interface kle_res_if;
    import kle_pkg::*;

    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] char_out;
    logic             is_empty;
    logic             overflowed;
    logic             last;

    modport source (output valid, output char_out, output is_empty, output overflowed,
                    output last, input ready);
    modport sink   (input valid, input char_out, input is_empty, input overflowed,
                    input last, output ready);
endinterface

// File: hw/rtl/keystroke_line_editor.sv
// Top level of the keystroke line editor: gap buffer held in two stack memories.
//
//  Channel   Dir  Handshake        Payload
//  i_req     in   valid / ready    op, key
//  o_res     out  valid / ready    char_out, is_empty, overflowed, last
//  i_cfg_*   in   write enable     i_cfg_idx, i_cfg_data
//
//  Insert, backspace and ignored keys complete in the idle state; left and right pass
//  through the move state (read of one stack memory, then write into the other).
//  Finish reads the first character, then loads each further character as the output
//  register is taken; an empty line gives a single result that is marked last.
//  Reset clears counts, overflow flag and control and loads the reset key codes; the stack memories are not cleared.
//  A stalled result holds the output register and the drain sequencer in place.
`timescale 1ns / 1ps

module keystroke_line_editor #(
    parameter int DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    kle_req_if.sink                       i_req,
    kle_res_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [kle_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kle_pkg::KEY_W-1:0]     i_cfg_data
);
    import kle_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE,
        S_DRAIN
    } t_state;

    typedef enum logic [1:0] {
        KEY_INSERT,
        KEY_BACK,
        KEY_LEFT,
        KEY_RIGHT
    } t_key_kind;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_bc, n_bc;
    logic [CW-1:0]     r_ac, n_ac;
    logic              r_ovf, n_ovf;
    logic              r_move_left, n_move_left;
    logic              r_empty, n_empty;
    logic              r_from_after, n_from_after;
    logic [CW-1:0]     r_pos, n_pos;
    logic [KEY_W-1:0]  r_bs_code, r_left_code, r_right_code;

    logic              r_out_valid, n_out_valid;
    logic [KEY_W-1:0]  r_char, n_char;
    logic              r_is_empty, n_is_empty;
    logic              r_out_ovf, n_out_ovf;
    logic              r_last, n_last;

    logic              w_accept;
    logic              w_load;
    logic              w_final;
    logic [CW-1:0]     w_total;
    logic [CW-1:0]     w_next;
    t_key_kind         w_kind;

    logic              b_we, b_re, a_we, a_re;
    logic [AW-1:0]     b_waddr, b_raddr, a_waddr, a_raddr;
    logic [KEY_W-1:0]  b_wdata, a_wdata, b_rdata, a_rdata;

    // Stack memories either side of the cursor
    kle_stack_mem #(.DEPTH(DEPTH), .AW(AW)) u_before (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_re    (b_re),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    kle_stack_mem #(.DEPTH(DEPTH), .AW(AW)) u_after (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_re    (a_re),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    assign w_total     = r_bc + r_ac;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_load      = (r_state == S_DRAIN) && (!r_out_valid || o_res.ready);
    assign w_final     = r_empty || (r_pos == w_total - ONE_C);
    assign w_next      = r_pos + ONE_C;

    // Decode the key; backspace wins over left, left over right
    always_comb begin
        if (i_req.key == r_bs_code) begin
            w_kind = KEY_BACK;
        end else if (i_req.key == r_left_code) begin
            w_kind = KEY_LEFT;
        end else if (i_req.key == r_right_code) begin
            w_kind = KEY_RIGHT;
        end else begin
            w_kind = KEY_INSERT;
        end
    end

    // Sequencer: next state, counts and memory requests
    always_comb begin
        n_state      = r_state;
        n_bc         = r_bc;
        n_ac         = r_ac;
        n_ovf        = r_ovf;
        n_move_left  = r_move_left;
        n_empty      = r_empty;
        n_from_after = r_from_after;
        n_pos        = r_pos;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_char       = r_char;
        n_is_empty   = r_is_empty;
        n_out_ovf    = r_out_ovf;
        n_last       = r_last;
        b_we         = 1'b0;
        b_re         = 1'b0;
        a_we         = 1'b0;
        a_re         = 1'b0;
        b_waddr      = r_bc[AW-1:0];
        a_waddr      = r_ac[AW-1:0];
        b_wdata      = i_req.key;
        a_wdata      = b_rdata;
        b_raddr      = '0;
        a_raddr      = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept && i_req.op == OP_FINISH) begin
                    // Start the drain: fetch the leftmost character
                    n_pos   = '0;
                    n_empty = (w_total == '0);
                    n_state = S_DRAIN;
                    if (r_bc != '0) begin
                        b_re         = 1'b1;
                        b_raddr      = '0;
                        n_from_after = 1'b0;
                    end else begin
                        a_re         = (r_ac != '0);
                        a_raddr      = AW'(r_ac - ONE_C);
                        n_from_after = 1'b1;
                    end
                end else if (w_accept) begin
                    case (w_kind)
                        KEY_BACK: begin
                            if (r_bc != '0) begin
                                n_bc = r_bc - ONE_C;
                            end
                        end
                        KEY_LEFT: begin
                            // Pop the before stack; push lands next cycle
                            if (r_bc != '0 && r_ac != DEPTH_C) begin
                                b_re        = 1'b1;
                                b_raddr     = AW'(r_bc - ONE_C);
                                n_bc        = r_bc - ONE_C;
                                n_move_left = 1'b1;
                                n_state     = S_MOVE;
                            end
                        end
                        KEY_RIGHT: begin
                            if (r_ac != '0 && r_bc != DEPTH_C) begin
                                a_re        = 1'b1;
                                a_raddr     = AW'(r_ac - ONE_C);
                                n_ac        = r_ac - ONE_C;
                                n_move_left = 1'b0;
                                n_state     = S_MOVE;
                            end
                        end
                        default: begin
                            // Insert at the cursor, or drop when full
                            if (w_total >= DEPTH_C) begin
                                n_ovf = 1'b1;
                            end else begin
                                b_we = 1'b1;
                                n_bc = r_bc + ONE_C;
                            end
                        end
                    endcase
                end
            end

            S_MOVE: begin
                // Push the popped character onto the other stack
                if (r_move_left) begin
                    a_we    = 1'b1;
                    a_wdata = b_rdata;
                    n_ac    = r_ac + ONE_C;
                end else begin
                    b_we    = 1'b1;
                    b_wdata = a_rdata;
                    n_bc    = r_bc + ONE_C;
                end
                n_state = S_IDLE;
            end

            S_DRAIN: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_is_empty  = r_empty;
                    n_out_ovf   = r_ovf;
                    n_last      = w_final;
                    if (r_empty) begin
                        n_char = '0;
                    end else if (r_from_after) begin
                        n_char = a_rdata;
                    end else begin
                        n_char = b_rdata;
                    end
                    if (w_final) begin
                        // Line done: clear the buffer
                        n_bc    = '0;
                        n_ac    = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        // Advance: before stack bottom-up, then after stack top-down
                        n_pos = w_next;
                        if (w_next < r_bc) begin
                            b_re         = 1'b1;
                            b_raddr      = w_next[AW-1:0];
                            n_from_after = 1'b0;
                        end else begin
                            a_re         = 1'b1;
                            a_raddr      = AW'(w_total - ONE_C - w_next);
                            n_from_after = 1'b1;
                        end
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, counts, codes and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_bc         <= '0;
            r_ac         <= '0;
            r_ovf        <= 1'b0;
            r_move_left  <= 1'b0;
            r_empty      <= 1'b0;
            r_from_after <= 1'b0;
            r_pos        <= '0;
            r_out_valid  <= 1'b0;
            r_bs_code    <= BACKSPACE_RESET;
            r_left_code  <= LEFT_RESET;
            r_right_code <= RIGHT_RESET;
        end else begin
            r_state      <= n_state;
            r_bc         <= n_bc;
            r_ac         <= n_ac;
            r_ovf        <= n_ovf;
            r_move_left  <= n_move_left;
            r_empty      <= n_empty;
            r_from_after <= n_from_after;
            r_pos        <= n_pos;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BACKSPACE: r_bs_code    <= i_cfg_data;
                    REG_LEFT:      r_left_code  <= i_cfg_data;
                    REG_RIGHT:     r_right_code <= i_cfg_data;
                    default:       ;
                endcase
            end
        end
        r_char     <= n_char;
        r_is_empty <= n_is_empty;
        r_out_ovf  <= n_out_ovf;
        r_last     <= n_last;
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.char_out   = r_char;
    assign o_res.is_empty   = r_is_empty;
    assign o_res.overflowed = r_out_ovf;
    assign o_res.last       = r_last;

    // The two stacks never hold more than the buffer depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_bc} + {1'b0, r_ac}) <= {1'b0, DEPTH_C})
        else $error("stack fill exceeds depth");

    // The final character of a line clears the buffer and frees the input
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_final) |=> (r_bc == '0 && r_ac == '0 && !r_ovf && r_state == S_IDLE))
        else $error("buffer not cleared after last character");

    // An empty line gives a single result that is also the last
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.is_empty) |-> o_res.last)
        else $error("empty result not marked last");

    // A cursor move completes its write-back and returns to idle on the next cycle
    a_move_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE) |=> (r_state == S_IDLE))
        else $error("cursor move did not complete");

endmodule

// File: hw/rtl/kle_stack_mem.sv
// One-write, one-read synchronous stack memory with registered read data.
`timescale 1ns / 1ps

module kle_stack_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [kle_pkg::KEY_W-1:0] i_wdata,
    input  logic                     i_re,
    input  logic [AW-1:0]            i_raddr,
    output logic [kle_pkg::KEY_W-1:0] o_rdata
);
    import kle_pkg::*;

    logic [KEY_W-1:0] r_mem [DEPTH];
    logic [KEY_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port: data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
